// ----- design/rtt_pkg.sv -----
// Package for the range top-two sum tree: sizes, codes and node merge.
// No dependencies; used by the core and the testbench.
`default_nettype none
package rtt_pkg;
    localparam int LEAVES     = 1024;
    localparam int LEAF_BITS  = $clog2(LEAVES);
    localparam int NODE_BITS  = LEAF_BITS + 1;
    localparam int NODES      = 2 * LEAVES;
    localparam int CNT_BITS   = 11;
    localparam int POS_BITS   = 10;
    localparam int VAL_BITS   = 31;
    localparam int NODE_W     = 32;
    localparam int PAIR_W     = 2 * NODE_W;
    localparam logic [NODE_W-1:0] EMPTY_MARK = '1;
    localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(1024);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_FEW   = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] top;
        logic [NODE_W-1:0] second;
    } t_pair;

    function automatic logic ranks_above(input logic [NODE_W-1:0] a,
                                         input logic [NODE_W-1:0] b);
        logic r;
        if (a == EMPTY_MARK) r = 1'b0;
        else if (b == EMPTY_MARK) r = 1'b1;
        else r = (a > b);
        return r;
    endfunction

    // Merge two top-two pairs; a wins ties.
    function automatic t_pair merge_pair(input t_pair a, input t_pair b);
        t_pair hi;
        t_pair lo;
        t_pair r;
        if (ranks_above(b.top, a.top)) begin
            hi = b;
            lo = a;
        end else begin
            hi = a;
            lo = b;
        end
        r.top    = hi.top;
        r.second = ranks_above(lo.top, hi.second) ? lo.top : hi.second;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- design/rtt_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/range_top_two_sum_tree_core.sv -----
// Top level of the range top-two sum tree: sequencer around one node RAM.
// Depends on rtt_pkg and rtt_ram.
//
//  port group   dir  handshake         contents
//  command      in   i_start / o_busy  kind, position, value, range bounds
//  result       out  o_done strobe     pair_sum, status
//  config       in   i_cfg_we          elements_in_use
//
// A write reads each sibling and writes the merged node back, level by level
// up to the root; a query fetches one node per visit from its lo/hi bounds and
// climbs a level when neither needs a fetch. Both are serialised by the single
// read port of the node RAM.
// Reset first clears all NODES nodes of the RAM, one node per cycle, with
// o_busy high. The result strobe cannot be stalled.
`default_nettype none
module range_top_two_sum_tree_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_kind,
    input  wire logic [rtt_pkg::POS_BITS-1:0] i_position,
    input  wire logic [rtt_pkg::VAL_BITS-1:0] i_value,
    input  wire logic [rtt_pkg::POS_BITS-1:0] i_range_first,
    input  wire logic [rtt_pkg::POS_BITS-1:0] i_range_last,
    input  wire logic                         i_cfg_we,
    input  wire logic [rtt_pkg::CNT_BITS-1:0] i_cfg_wdata,
    output logic                              o_done,
    output logic [31:0]                       o_pair_sum,
    output logic [1:0]                        o_status
);
    localparam int NB = rtt_pkg::NODE_BITS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WSIB, S_WWAIT, S_WMERGE,
        S_QSTEP, S_QWAIT, S_QMERGE, S_QDONE
    } t_state;

    t_state r_state;
    logic [rtt_pkg::CNT_BITS-1:0] r_count;
    logic [NB-1:0] r_k;        // write path node / query lo
    logic [NB:0]   r_hi;       // query hi (exclusive, may reach NODES)
    logic          r_hi_side;  // current query fetch came from hi
    rtt_pkg::t_pair r_cur;     // write: current node pair; query: accumulator

    // RAM port
    logic           w_we;
    logic [NB-1:0]  w_waddr;
    rtt_pkg::t_pair w_wdata;
    logic [NB-1:0]  w_raddr;
    rtt_pkg::t_pair w_rdata;

    rtt_ram #(.WIDTH(rtt_pkg::PAIR_W), .DEPTH(rtt_pkg::NODES)) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic [rtt_pkg::CNT_BITS-1:0] w_n;
    assign w_n = (r_count < rtt_pkg::CNT_BITS'(rtt_pkg::LEAVES)) ? r_count
               : rtt_pkg::CNT_BITS'(rtt_pkg::LEAVES);

    rtt_pkg::t_pair w_merged;
    rtt_pkg::t_pair w_leaf;
    assign w_leaf.top    = {1'b0, i_value};
    assign w_leaf.second = rtt_pkg::EMPTY_MARK;

    // Merge current node with its sibling; keep left/right order.
    always_comb begin
        if (r_k[0]) w_merged = rtt_pkg::merge_pair(w_rdata, r_cur);
        else        w_merged = rtt_pkg::merge_pair(r_cur, w_rdata);
    end

    rtt_pkg::t_pair w_qmerged;
    assign w_qmerged = rtt_pkg::merge_pair(r_cur, w_rdata);

    // Drive RAM port from state
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_k;
        w_wdata = r_cur;
        w_raddr = r_k ^ NB'(1);
        case (r_state)
            S_CLEAR: begin
                w_we          = 1'b1;
                w_wdata.top   = rtt_pkg::EMPTY_MARK;
                w_wdata.second = rtt_pkg::EMPTY_MARK;
            end
            S_WSIB: begin
                w_we = 1'b1;
            end
            // Hold the query fetch address until the merge sees its word
            S_QSTEP, S_QWAIT: begin
                w_raddr = r_k[0] ? r_k : NB'(r_hi - 1'b1);
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_count    <= rtt_pkg::CNT_RESET;
            r_k        <= '0;
            o_done     <= 1'b0;
            o_busy     <= 1'b1;
            o_pair_sum <= '0;
            o_status   <= rtt_pkg::ST_OK;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) r_count <= i_cfg_wdata;
            case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == NB'(rtt_pkg::NODES - 1)) begin
                        r_state <= S_IDLE;
                        o_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        o_pair_sum <= '0;
                        if (i_kind == 1'b0) begin
                            if ({1'b0, i_position} >= w_n) begin
                                o_done   <= 1'b1;
                                o_status <= rtt_pkg::ST_BAD;
                            end else begin
                                r_k     <= NB'(rtt_pkg::LEAVES) + NB'(i_position);
                                r_cur   <= w_leaf;
                                r_state <= S_WSIB;
                                o_busy  <= 1'b1;
                            end
                        end else if (i_range_first > i_range_last
                                     || {1'b0, i_range_last} >= w_n) begin
                            o_done   <= 1'b1;
                            o_status <= rtt_pkg::ST_BAD;
                        end else if (i_range_first == i_range_last) begin
                            o_done   <= 1'b1;
                            o_status <= rtt_pkg::ST_FEW;
                        end else begin
                            r_k    <= NB'(rtt_pkg::LEAVES) + NB'(i_range_first);
                            r_hi   <= (NB+1)'(rtt_pkg::LEAVES) + (NB+1)'(i_range_last)
                                      + (NB+1)'(1);
                            r_cur.top    <= rtt_pkg::EMPTY_MARK;
                            r_cur.second <= rtt_pkg::EMPTY_MARK;
                            r_state <= S_QSTEP;
                            o_busy  <= 1'b1;
                        end
                    end
                end
                // Write node r_k, read its sibling
                S_WSIB: begin
                    if (r_k == NB'(1)) begin
                        o_done   <= 1'b1;
                        o_status <= rtt_pkg::ST_WRITE;
                        o_busy   <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_WWAIT;
                    end
                end
                S_WWAIT: r_state <= S_WMERGE;
                S_WMERGE: begin
                    r_cur   <= w_merged;
                    r_k     <= r_k >> 1;
                    r_state <= S_WSIB;
                end
                // Walk lo/hi bounds; fetch one node per visit
                S_QSTEP: begin
                    if ({1'b0, r_k} >= r_hi) begin
                        r_state <= S_QDONE;
                    end else if (r_k[0]) begin
                        r_hi_side <= 1'b0;
                        r_state   <= S_QWAIT;
                    end else if (r_hi[0]) begin
                        r_hi_side <= 1'b1;
                        r_state   <= S_QWAIT;
                    end else begin
                        r_k  <= r_k >> 1;
                        r_hi <= r_hi >> 1;
                    end
                end
                S_QWAIT: r_state <= S_QMERGE;
                S_QMERGE: begin
                    r_cur   <= w_qmerged;
                    r_state <= S_QSTEP;
                    if (r_hi_side) r_hi <= r_hi - 1'b1;
                    else           r_k  <= r_k + 1'b1;
                end
                S_QDONE: begin
                    o_done  <= 1'b1;
                    o_busy  <= 1'b0;
                    r_state <= S_IDLE;
                    if (r_cur.top == rtt_pkg::EMPTY_MARK
                        || r_cur.second == rtt_pkg::EMPTY_MARK) begin
                        o_status <= rtt_pkg::ST_FEW;
                    end else begin
                        o_status   <= rtt_pkg::ST_OK;
                        o_pair_sum <= r_cur.top + r_cur.second;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for range_top_two_sum_tree_core: drives writes and range queries,
// predicts each result word with a software segment tree, and checks it.
// Depends on rtt_pkg and the design files.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    // Track expected pair sums against a local copy of the tree
    class pair_sum_board;
        logic [rtt_pkg::NODE_W-1:0] top_q[rtt_pkg::NODES];
        logic [rtt_pkg::NODE_W-1:0] sec_q[rtt_pkg::NODES];
        int unsigned count_in_use;
        logic [31:0] sum_q[$];
        logic [1:0] status_q[$];
        int errors;

        function void clear_tree();
            for (int k = 0; k < rtt_pkg::NODES; k++) begin
                top_q[k] = rtt_pkg::EMPTY_MARK;
                sec_q[k] = rtt_pkg::EMPTY_MARK;
            end
            count_in_use = 1024;
            errors = 0;
        endfunction

        function bit above(logic [rtt_pkg::NODE_W-1:0] a, logic [rtt_pkg::NODE_W-1:0] b);
            if (a == rtt_pkg::EMPTY_MARK) return 1'b0;
            if (b == rtt_pkg::EMPTY_MARK) return 1'b1;
            return a > b;
        endfunction

        // Combine pair a with pair b into (t, s); a wins ties
        function void combine(inout logic [rtt_pkg::NODE_W-1:0] at,
                              inout logic [rtt_pkg::NODE_W-1:0] as_,
                              input logic [rtt_pkg::NODE_W-1:0] bt,
                              input logic [rtt_pkg::NODE_W-1:0] bs);
            logic [rtt_pkg::NODE_W-1:0] ht, hs, lt;
            if (above(bt, at)) begin
                ht = bt; hs = bs; lt = at;
            end else begin
                ht = at; hs = as_; lt = bt;
            end
            at = ht;
            as_ = above(lt, hs) ? lt : hs;
        endfunction

        function void note_command(bit kind, int unsigned pos, logic [30:0] val,
                                   int unsigned first, int unsigned last);
            int unsigned n, k, lo, hi;
            logic [rtt_pkg::NODE_W-1:0] t, s;
            n = (count_in_use < rtt_pkg::LEAVES) ? count_in_use : rtt_pkg::LEAVES;
            sum_q.push_back(32'd0);
            if (kind == 1'b0) begin
                if (pos >= n) begin
                    status_q.push_back(rtt_pkg::ST_BAD);
                    return;
                end
                k = rtt_pkg::LEAVES + pos;
                top_q[k] = {1'b0, val};
                sec_q[k] = rtt_pkg::EMPTY_MARK;
                while (k > 1) begin
                    k = k >> 1;
                    t = top_q[2*k];
                    s = sec_q[2*k];
                    combine(t, s, top_q[2*k+1], sec_q[2*k+1]);
                    top_q[k] = t;
                    sec_q[k] = s;
                end
                status_q.push_back(rtt_pkg::ST_WRITE);
                return;
            end
            if (first > last || last >= n) begin
                status_q.push_back(rtt_pkg::ST_BAD);
                return;
            end
            if (first == last) begin
                status_q.push_back(rtt_pkg::ST_FEW);
                return;
            end
            t = rtt_pkg::EMPTY_MARK;
            s = rtt_pkg::EMPTY_MARK;
            lo = rtt_pkg::LEAVES + first;
            hi = rtt_pkg::LEAVES + last + 1;
            while (lo < hi) begin
                if (lo & 1) begin
                    combine(t, s, top_q[lo], sec_q[lo]);
                    lo++;
                end
                if (hi & 1) begin
                    hi--;
                    combine(t, s, top_q[hi], sec_q[hi]);
                end
                lo = lo >> 1;
                hi = hi >> 1;
            end
            if (t == rtt_pkg::EMPTY_MARK || s == rtt_pkg::EMPTY_MARK) begin
                status_q.push_back(rtt_pkg::ST_FEW);
                return;
            end
            sum_q[$] = t + s;
            status_q.push_back(rtt_pkg::ST_OK);
        endfunction

        function void check_word(logic [31:0] sum, logic [1:0] status);
            logic [31:0] es;
            logic [1:0] est;
            if (status_q.size() == 0) begin
                $error("result word with nothing expected: sum %0d status %0d", sum, status);
                errors++;
                return;
            end
            es = sum_q.pop_front();
            est = status_q.pop_front();
            if (sum !== es) begin
                $error("pair_sum: expected %0d, got %0d", es, sum);
                errors++;
            end
            if (status !== est) begin
                $error("status: expected %0d, got %0d", est, status);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic kind = 1'b0;
    logic [rtt_pkg::POS_BITS-1:0] position = '0;
    logic [rtt_pkg::VAL_BITS-1:0] value = '0;
    logic [rtt_pkg::POS_BITS-1:0] range_first = '0;
    logic [rtt_pkg::POS_BITS-1:0] range_last = '0;
    logic cfg_we = 1'b0;
    logic [rtt_pkg::CNT_BITS-1:0] cfg_wdata = '0;
    logic busy, done;
    logic [31:0] pair_sum;
    logic [1:0] status;
    int unsigned cycles = 0;
    int unsigned live_count = 1024;
    bit calm = 1'b0;
    pair_sum_board board;

    always #6 clk = ~clk;

    range_top_two_sum_tree_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_kind(kind), .i_position(position), .i_value(value),
        .i_range_first(range_first), .i_range_last(range_last),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_done(done), .o_pair_sum(pair_sum), .o_status(status)
    );

    // Check each result word at the edge that accepts it
    always @(posedge clk) begin
        if (rst_n && done) board.check_word(pair_sum, status);
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Send one command word; hold start until the block takes it
    task automatic send_word(bit k, int unsigned pos, logic [30:0] val,
                             int unsigned first, int unsigned last);
        bit taken;
        while (!calm && $urandom_range(99) < 18) @(negedge clk);
        start = 1'b1;
        kind = k;
        position = pos[rtt_pkg::POS_BITS-1:0];
        value = val;
        range_first = first[rtt_pkg::POS_BITS-1:0];
        range_last = last[rtt_pkg::POS_BITS-1:0];
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = !busy;
            if (taken) board.note_command(k, pos, val, first, last);
            @(negedge clk);
        end
        start = 1'b0;
    endtask

    // Wait for the block to drain, then settle before a register write
    task automatic drain();
        while (board.status_q.size() != 0 || busy) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_count(int unsigned n);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = n[rtt_pkg::CNT_BITS-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        board.count_in_use = n;
        live_count = (n < rtt_pkg::LEAVES) ? n : rtt_pkg::LEAVES;
    endtask

    // Random word: writes and queries mostly in bounds, some out of range
    task automatic random_word(int unsigned span);
        int unsigned a, b;
        logic [30:0] v;
        v = ($urandom_range(7) == 0) ? 31'h7FFF_FFFF - 31'($urandom_range(3))
                                     : 31'($urandom);
        a = $urandom_range(span - 1);
        b = $urandom_range(span - 1);
        if ($urandom_range(9) == 0) begin
            a = $urandom_range(1023);
            b = $urandom_range(1023);
        end else if (a > b && $urandom_range(3) != 0) begin
            int unsigned t;
            t = a; a = b; b = t;
        end
        send_word(1'($urandom_range(1)), a, v, a, b);
    endtask

    initial begin
        board = new();
        board.clear_tree();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty queries, extremes, single and reversed ranges
        send_word(1'b1, 0, 0, 0, 1023);
        send_word(1'b1, 5, 0, 5, 5);
        send_word(1'b1, 9, 0, 8, 3);
        send_word(1'b0, 0, 31'h7FFF_FFFF, 0, 0);
        send_word(1'b1, 0, 0, 0, 1023);
        send_word(1'b0, 1023, 31'h7FFF_FFFF, 0, 0);
        send_word(1'b1, 0, 0, 0, 1023);
        send_word(1'b0, 512, 0, 0, 0);
        send_word(1'b0, 513, 0, 0, 0);
        send_word(1'b1, 0, 0, 512, 513);
        send_word(1'b0, 1, 31'h5555_5555, 0, 0);
        send_word(1'b0, 2, 31'h2AAA_AAAA, 0, 0);
        send_word(1'b1, 0, 0, 1, 2);
        send_word(1'b1, 0, 0, 0, 2);
        send_word(1'b1, 0, 0, 1022, 1023);

        set_count(0);
        send_word(1'b0, 0, 7, 0, 0);
        send_word(1'b1, 0, 0, 0, 1);
        set_count(2047);
        send_word(1'b1, 0, 0, 0, 1023);
        set_count(2);
        send_word(1'b0, 2, 9, 0, 0);
        send_word(1'b1, 0, 0, 0, 1);
        send_word(1'b1, 0, 0, 0, 2);
        set_count(1);
        send_word(1'b1, 0, 0, 0, 1);

        // Random phases over several counts; one stretch without gaps
        set_count(16);
        for (int i = 0; i < 150; i++) random_word(live_count + 1);
        set_count(1024);
        calm = 1'b1;
        for (int i = 0; i < 100; i++) random_word(live_count);
        calm = 1'b0;
        for (int i = 0; i < 100; i++) random_word(live_count);
        set_count(37);
        for (int i = 0; i < 150; i++) random_word(live_count + 2);

        drain();
        repeat (60) @(negedge clk);
        if (board.errors == 0 && board.status_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- range_top_two_sum_tree_core.f -----
design/rtt_pkg.sv
design/rtt_ram.sv
design/range_top_two_sum_tree_core.sv
test/tb_top.sv
